[design/tct_pkg.sv]
// Shared types and codes for the two-class countdown timer table.
// Holds the timer entry struct, request action codes and result kinds.
// No dependencies.
`default_nettype none

package tct_pkg;

  localparam int unsigned TIME_W   = 16;
  localparam int unsigned HANDLE_W = 8;
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned KIND_W   = 2;

  typedef logic [TIME_W-1:0]   time_t;
  typedef logic [HANDLE_W-1:0] handle_t;
  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [KIND_W-1:0]   kind_t;

  typedef struct packed {
    time_t   tm;
    handle_t hdl;
    logic    vld;
  } entry_t;

  localparam action_t ACT_ADD   = 3'd0;
  localparam action_t ACT_DEL   = 3'd1;
  localparam action_t ACT_QUERY = 3'd2;
  localparam action_t ACT_TICK  = 3'd3;
  localparam action_t ACT_SERV  = 3'd4;

  localparam kind_t KIND_DONE    = 2'd0;
  localparam kind_t KIND_REJECT  = 2'd1;
  localparam kind_t KIND_REMAIN  = 2'd2;
  localparam kind_t KIND_EXPIRED = 2'd3;

endpackage

`default_nettype wire

[design/tct_cell.sv]
// One timer slot: time, handle and valid mark.
// Loads the neighbor's entry on every shift. Depends on tct_pkg.
`default_nettype none

module tct_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            shift_i,
  input  wire tct_pkg::entry_t entry_i,
  output tct_pkg::entry_t      entry_o
);
  import tct_pkg::*;

  entry_t entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else if (shift_i) begin
      entry_q <= entry_i;
    end
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

[design/tct_row.sv]
// Ring of timer cells: the head cell is presented for processing and the
// processed entry reenters at the tail. Depends on tct_pkg and tct_cell.
`default_nettype none

module tct_row #(
  parameter int unsigned DEPTH = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            shift_i,
  input  wire tct_pkg::entry_t tail_i,
  output tct_pkg::entry_t      head_o
);
  import tct_pkg::*;

  entry_t cell_q [DEPTH];

  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    entry_t nbr;
    if (j == DEPTH - 1) begin : g_tail
      assign nbr = tail_i;
    end else begin : g_mid
      assign nbr = cell_q[j+1];
    end
    tct_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift_i),
      .entry_i (nbr),
      .entry_o (cell_q[j])
    );
  end

  assign head_o = cell_q[0];

endmodule

`default_nettype wire

[design/two_class_countdown_timer_table.sv]
// Two-class countdown timer table: top level with request sequencer.
// Depends on tct_pkg and tct_row (normal and quick rings of cells).
//
// Usage: a request (action, handle, delay, quick_class, late_in_tick) is
// taken at a clock edge where start is high and busy is low. Results come
// out one per cycle on kind_o/handle_res_o/remaining_o/last_o, each marked
// by a one-cycle valid_o pulse; last_o marks the final result of a request.
// The receiver cannot hold results off, so no result waits.
// Each table is a ring of cells rotated once per cycle past a single
// processing point, so a pass over a table visits each of its slots once
// (N = NORMAL_SLOTS, Q = QUICK_SLOTS) and ends with the ring in its
// original order. Expired timers are reported while the pass runs.
// Passes per request: add walks the table chosen by quick_class, tick the
// quick table, service the normal table; delete and query walk the normal
// table, then the quick table when no normal entry matched. An unknown
// action gets one reject reply in the next cycle, and busy does not rise.
// A new request may be taken at the edge that ends the last_o cycle.
// Reset clears every slot, the tick backlog and the sequencer; no sweep.
`default_nettype none

module two_class_countdown_timer_table #(
  parameter int unsigned NORMAL_SLOTS = 8,
  parameter int unsigned QUICK_SLOTS  = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire tct_pkg::action_t action_i,
  input  wire tct_pkg::handle_t handle_i,
  input  wire tct_pkg::time_t   delay_i,
  input  wire logic             quick_class_i,
  input  wire logic             late_in_tick_i,
  output logic                  valid_o,
  output tct_pkg::kind_t        kind_o,
  output tct_pkg::handle_t      handle_res_o,
  output tct_pkg::time_t        remaining_o,
  output logic                  last_o
);
  import tct_pkg::*;

  localparam int unsigned MAX_SLOTS = (NORMAL_SLOTS > QUICK_SLOTS) ? NORMAL_SLOTS : QUICK_SLOTS;
  localparam int unsigned CNT_W     = $clog2(MAX_SLOTS + 1);
  localparam logic [CNT_W-1:0] N_LAST = CNT_W'(NORMAL_SLOTS - 1);
  localparam logic [CNT_W-1:0] Q_LAST = CNT_W'(QUICK_SLOTS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NPASS,
    ST_QPASS,
    ST_FIN
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] step_q;
  action_t          act_q;
  handle_t          handle_q;
  time_t            delay_q;
  logic             found_q;
  time_t            rem_q;
  time_t            backlog_q;

  entry_t n_head, n_new, q_head, q_new;
  logic   n_hit, q_hit, n_exp, q_exp;
  logic   n_match, q_match;
  time_t  q_dec;
  time_t  delay_adj;

  assign n_match   = n_head.vld && (n_head.hdl == handle_q);
  assign q_match   = q_head.vld && (q_head.hdl == handle_q);
  assign q_dec     = q_head.tm - time_t'(1);
  assign delay_adj = (late_in_tick_i && (delay_i > time_t'(1))) ? delay_i - time_t'(1) : delay_i;

  // Normal head: add, delete, query, service
  always_comb begin
    n_new = n_head;
    n_hit = 1'b0;
    n_exp = 1'b0;
    case (act_q)
      ACT_ADD: begin
        if (!found_q && (n_head.tm == '0)) begin
          n_new = '{tm: delay_q, hdl: handle_q, vld: 1'b1};
          n_hit = 1'b1;
        end
      end
      ACT_DEL: begin
        if (!found_q && n_match) begin
          n_new.tm  = '0;
          n_new.vld = 1'b0;
          n_hit     = 1'b1;
        end
      end
      ACT_QUERY: begin
        n_hit = !found_q && n_match;
      end
      ACT_SERV: begin
        if (n_head.tm != '0) begin
          if (n_head.tm > backlog_q) begin
            n_new.tm = n_head.tm - backlog_q;
          end else begin
            n_new.tm  = '0;
            n_new.vld = 1'b0;
            n_exp     = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Quick head: add, delete, query, tick
  always_comb begin
    q_new = q_head;
    q_hit = 1'b0;
    q_exp = 1'b0;
    case (act_q)
      ACT_ADD: begin
        if (!found_q && (q_head.tm == '0)) begin
          q_new = '{tm: delay_q, hdl: handle_q, vld: 1'b1};
          q_hit = 1'b1;
        end
      end
      ACT_DEL: begin
        if (!found_q && q_match) begin
          q_new.tm  = '0;
          q_new.vld = 1'b0;
          q_hit     = 1'b1;
        end
      end
      ACT_QUERY: begin
        q_hit = !found_q && q_match;
      end
      ACT_TICK: begin
        if (q_head.tm != '0) begin
          q_new.tm = q_dec;
          if (q_dec == '0) begin
            q_new.vld = 1'b0;
            q_exp     = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  tct_row #(.DEPTH(NORMAL_SLOTS)) u_normal (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (state_q == ST_NPASS),
    .tail_i  (n_new),
    .head_o  (n_head)
  );

  tct_row #(.DEPTH(QUICK_SLOTS)) u_quick (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (state_q == ST_QPASS),
    .tail_i  (q_new),
    .head_o  (q_head)
  );

  assign busy = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      step_q       <= '0;
      act_q        <= ACT_ADD;
      handle_q     <= '0;
      delay_q      <= '0;
      found_q      <= 1'b0;
      rem_q        <= '0;
      backlog_q    <= '0;
      valid_o      <= 1'b0;
      kind_o       <= KIND_DONE;
      handle_res_o <= '0;
      remaining_o  <= '0;
      last_o       <= 1'b0;
    end else begin
      valid_o <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            act_q    <= action_i;
            handle_q <= handle_i;
            delay_q  <= delay_adj;
            found_q  <= 1'b0;
            rem_q    <= '0;
            step_q   <= '0;
            case (action_i)
              ACT_ADD: begin
                state_q <= quick_class_i ? ST_QPASS : ST_NPASS;
              end
              ACT_DEL, ACT_QUERY, ACT_SERV: begin
                state_q <= ST_NPASS;
              end
              ACT_TICK: begin
                if (backlog_q != '1) begin
                  backlog_q <= backlog_q + time_t'(1);
                end
                state_q <= ST_QPASS;
              end
              default: begin
                // unknown action: single reject, nothing changes
                valid_o      <= 1'b1;
                kind_o       <= KIND_REJECT;
                handle_res_o <= handle_i;
                remaining_o  <= '0;
                last_o       <= 1'b1;
              end
            endcase
          end
        end
        ST_NPASS: begin
          step_q <= step_q + CNT_W'(1);
          if (n_hit) begin
            found_q <= 1'b1;
            rem_q   <= n_head.tm;
          end
          if (n_exp) begin
            valid_o      <= 1'b1;
            kind_o       <= KIND_EXPIRED;
            handle_res_o <= n_head.hdl;
            remaining_o  <= '0;
            last_o       <= 1'b0;
          end
          if (step_q == N_LAST) begin
            step_q <= '0;
            // fall back to the quick table when no normal entry matched
            if (((act_q == ACT_DEL) || (act_q == ACT_QUERY)) && !found_q && !n_hit) begin
              state_q <= ST_QPASS;
            end else begin
              state_q <= ST_FIN;
            end
          end
        end
        ST_QPASS: begin
          step_q <= step_q + CNT_W'(1);
          if (q_hit) begin
            found_q <= 1'b1;
            rem_q   <= q_head.tm;
          end
          if (q_exp) begin
            valid_o      <= 1'b1;
            kind_o       <= KIND_EXPIRED;
            handle_res_o <= q_head.hdl;
            remaining_o  <= '0;
            last_o       <= 1'b0;
          end
          if (step_q == Q_LAST) begin
            step_q  <= '0;
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          valid_o      <= 1'b1;
          handle_res_o <= handle_q;
          last_o       <= 1'b1;
          remaining_o  <= '0;
          case (act_q)
            ACT_ADD, ACT_DEL: begin
              kind_o <= found_q ? KIND_DONE : KIND_REJECT;
            end
            ACT_QUERY: begin
              kind_o      <= found_q ? KIND_REMAIN : KIND_REJECT;
              remaining_o <= found_q ? rem_q : '0;
            end
            ACT_SERV: begin
              kind_o    <= KIND_DONE;
              backlog_q <= '0;
            end
            default: begin
              kind_o <= KIND_DONE;
            end
          endcase
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[dv/tb_two_class_countdown_timer_table.sv]
// Self-checking testbench for two_class_countdown_timer_table.
// Drives requests from a queue, predicts every result with its own timer table
// model and checks results in order. Depends on tct_pkg and the block RTL.
module tb_two_class_countdown_timer_table;
  import tct_pkg::*;

  localparam int unsigned NORMAL_SLOTS  = 8;
  localparam int unsigned QUICK_SLOTS   = 4;
  localparam int unsigned RANDOM_REQS   = 370;
  localparam int unsigned BACKLOG_TICKS = 20;
  localparam int unsigned POOL_SIZE     = 6;
  localparam int unsigned TAIL_CYCLES   = NORMAL_SLOTS + QUICK_SLOTS + 8;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam action_t     ACT_TOP       = '1;

  typedef struct {
    action_t     act;
    handle_t     hdl;
    time_t       dly;
    logic        quick;
    logic        late;
    int unsigned idle;
    bit          drain;
  } request_t;

  typedef struct packed {
    kind_t   kind;
    handle_t hdl;
    time_t   rem;
    logic    last;
  } reply_t;

  logic    clk_i          = 1'b0;
  logic    rst_ni         = 1'b0;
  logic    start          = 1'b0;
  action_t action_i       = ACT_ADD;
  handle_t handle_i       = '0;
  time_t   delay_i        = '0;
  logic    quick_class_i  = 1'b0;
  logic    late_in_tick_i = 1'b0;
  logic    busy;
  logic    valid_o;
  kind_t   kind_o;
  handle_t handle_res_o;
  time_t   remaining_o;
  logic    last_o;

  // Timer table prediction state
  entry_t      normal_tab[NORMAL_SLOTS];
  entry_t      quick_tab[QUICK_SLOTS];
  time_t       backlog;

  reply_t      due_replies[$];
  request_t    pending[$];
  request_t    in_flight;
  int unsigned replies_due_total = 0;
  int unsigned replies_seen      = 0;
  int unsigned mismatches        = 0;
  int unsigned cycle_cnt         = 0;

  two_class_countdown_timer_table #(
    .NORMAL_SLOTS(NORMAL_SLOTS),
    .QUICK_SLOTS (QUICK_SLOTS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .action_i      (action_i),
    .handle_i      (handle_i),
    .delay_i       (delay_i),
    .quick_class_i (quick_class_i),
    .late_in_tick_i(late_in_tick_i),
    .valid_o       (valid_o),
    .kind_o        (kind_o),
    .handle_res_o  (handle_res_o),
    .remaining_o   (remaining_o),
    .last_o        (last_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic void push_reply(kind_t kind, handle_t hdl, time_t rem, logic last);
    reply_t rp;
    rp.kind = kind;
    rp.hdl  = hdl;
    rp.rem  = rem;
    rp.last = last;
    due_replies.push_back(rp);
    replies_due_total++;
  endfunction

  // Apply one accepted request to the table copy and queue the replies it owes.
  function automatic void advance_timer_model(input request_t r);
    time_t d;
    int    nhit;
    int    qhit;
    int    i;
    nhit = -1;
    qhit = -1;
    d    = r.dly;
    case (r.act)
      ACT_ADD: begin
        if (d > 1 && r.late) d = d - 1'b1;
        if (r.quick) begin
          for (i = int'(QUICK_SLOTS) - 1; i >= 0; i--)
            if (quick_tab[i].tm == '0) qhit = i;
          if (qhit >= 0) quick_tab[qhit] = '{tm: d, hdl: r.hdl, vld: 1'b1};
          push_reply(qhit >= 0 ? KIND_DONE : KIND_REJECT, r.hdl, '0, 1'b1);
        end else begin
          for (i = int'(NORMAL_SLOTS) - 1; i >= 0; i--)
            if (normal_tab[i].tm == '0) nhit = i;
          if (nhit >= 0) normal_tab[nhit] = '{tm: d, hdl: r.hdl, vld: 1'b1};
          push_reply(nhit >= 0 ? KIND_DONE : KIND_REJECT, r.hdl, '0, 1'b1);
        end
      end
      ACT_DEL, ACT_QUERY: begin
        // normal table wins; fall back to the quick table
        for (i = int'(NORMAL_SLOTS) - 1; i >= 0; i--)
          if (normal_tab[i].vld && normal_tab[i].hdl == r.hdl) nhit = i;
        if (nhit < 0) begin
          for (i = int'(QUICK_SLOTS) - 1; i >= 0; i--)
            if (quick_tab[i].vld && quick_tab[i].hdl == r.hdl) qhit = i;
        end
        if (nhit < 0 && qhit < 0) begin
          push_reply(KIND_REJECT, r.hdl, '0, 1'b1);
        end else if (r.act == ACT_QUERY) begin
          push_reply(KIND_REMAIN, r.hdl,
                     nhit >= 0 ? normal_tab[nhit].tm : quick_tab[qhit].tm, 1'b1);
        end else begin
          if (nhit >= 0) begin
            normal_tab[nhit].tm  = '0;
            normal_tab[nhit].vld = 1'b0;
          end else begin
            quick_tab[qhit].tm  = '0;
            quick_tab[qhit].vld = 1'b0;
          end
          push_reply(KIND_DONE, r.hdl, '0, 1'b1);
        end
      end
      ACT_TICK: begin
        if (backlog != '1) backlog = backlog + 1'b1;
        for (i = 0; i < int'(QUICK_SLOTS); i++) begin
          if (quick_tab[i].tm != '0) begin
            quick_tab[i].tm = quick_tab[i].tm - 1'b1;
            if (quick_tab[i].tm == '0) begin
              quick_tab[i].vld = 1'b0;
              push_reply(KIND_EXPIRED, quick_tab[i].hdl, '0, 1'b0);
            end
          end
        end
        push_reply(KIND_DONE, r.hdl, '0, 1'b1);
      end
      ACT_SERV: begin
        for (i = 0; i < int'(NORMAL_SLOTS); i++) begin
          if (normal_tab[i].tm != '0) begin
            if (normal_tab[i].tm > backlog) begin
              normal_tab[i].tm = normal_tab[i].tm - backlog;
            end else begin
              normal_tab[i].tm  = '0;
              normal_tab[i].vld = 1'b0;
              push_reply(KIND_EXPIRED, normal_tab[i].hdl, '0, 1'b0);
            end
          end
        end
        backlog = '0;
        push_reply(KIND_DONE, r.hdl, '0, 1'b1);
      end
      default: push_reply(KIND_REJECT, r.hdl, '0, 1'b1);
    endcase
  endfunction

  function automatic void queue_req(action_t act, handle_t hdl, time_t dly,
                                    logic quick, logic late);
    request_t r;
    r.act   = act;
    r.hdl   = hdl;
    r.dly   = dly;
    r.quick = quick;
    r.late  = late;
    r.idle  = 0;
    r.drain = 1'b0;
    pending.push_back(r);
  endfunction

  // Request driver
  always @(posedge clk_i) begin
    int i;
    if (!rst_ni) begin
      start <= 1'b0;
      for (i = 0; i < int'(NORMAL_SLOTS); i++) normal_tab[i] = '0;
      for (i = 0; i < int'(QUICK_SLOTS); i++) quick_tab[i] = '0;
      backlog = '0;
    end else begin
      if (start && !busy) advance_timer_model(in_flight);
      if (start && busy) begin
        // hold until taken
      end else if (pending.size() == 0) begin
        start <= 1'b0;
      end else if (pending[0].idle != 0) begin
        pending[0].idle = pending[0].idle - 1;
        start <= 1'b0;
      end else if (pending[0].drain && replies_seen != replies_due_total) begin
        start <= 1'b0;
      end else begin
        in_flight = pending.pop_front();
        start          <= 1'b1;
        action_i       <= in_flight.act;
        handle_i       <= in_flight.hdl;
        delay_i        <= in_flight.dly;
        quick_class_i  <= in_flight.quick;
        late_in_tick_i <= in_flight.late;
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && valid_o) begin
      replies_seen <= replies_seen + 1;
      if (due_replies.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected result: kind %0d handle %0d remaining %0d last %0b",
                   kind_o, handle_res_o, remaining_o, last_o);
        mismatches++;
      end else begin
        want = due_replies.pop_front();
        if (kind_o !== want.kind || handle_res_o !== want.hdl ||
            remaining_o !== want.rem || last_o !== want.last) begin
          if (mismatches < MAX_REPORTS) begin
            $display("mismatch: expected kind %0d handle %0d remaining %0d last %0b",
                     want.kind, want.hdl, want.rem, want.last);
            $display("          got kind %0d handle %0d remaining %0d last %0b",
                     kind_o, handle_res_o, remaining_o, last_o);
          end
          mismatches++;
        end
      end
    end
  end

  // Reset and watchdog
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Stimulus and end of run
  initial begin
    handle_t     pool[POOL_SIZE];
    request_t    r;
    int unsigned i;
    int unsigned sel;
    bit          calm;

    // empty table, cut of late delays, zero delay, quick overwrite of a zero slot
    queue_req(ACT_QUERY, 8'h00, 16'h0000, 1'b0, 1'b0);
    queue_req(ACT_DEL,   8'hFF, 16'hFFFF, 1'b1, 1'b1);
    queue_req(ACT_ADD,   8'h00, 16'hFFFF, 1'b0, 1'b1);
    queue_req(ACT_ADD,   8'hFF, 16'h0000, 1'b0, 1'b1);
    queue_req(ACT_ADD,   8'h5A, 16'h0001, 1'b0, 1'b1);
    queue_req(ACT_ADD,   8'hA5, 16'h0002, 1'b0, 1'b1);
    queue_req(ACT_ADD,   8'h11, 16'h0001, 1'b1, 1'b0);
    queue_req(ACT_ADD,   8'h22, 16'h0003, 1'b1, 1'b1);
    queue_req(ACT_ADD,   8'h33, 16'hFFFF, 1'b1, 1'b0);
    queue_req(ACT_ADD,   8'h44, 16'h0000, 1'b1, 1'b0);
    queue_req(ACT_ADD,   8'h55, 16'h0005, 1'b1, 1'b0);
    queue_req(ACT_ADD,   8'h66, 16'h0004, 1'b1, 1'b1);
    queue_req(ACT_QUERY, 8'hFF, 16'h0000, 1'b0, 1'b0);
    queue_req(ACT_QUERY, 8'h33, 16'h0000, 1'b0, 1'b0);
    queue_req(ACT_TICK,  8'h01, 16'h0000, 1'b0, 1'b0);
    queue_req(ACT_TICK,  8'h80, 16'h0000, 1'b1, 1'b1);
    queue_req(ACT_SERV,  8'h7E, 16'h0000, 1'b0, 1'b0);
    queue_req(ACT_DEL,   8'hFF, 16'h0000, 1'b0, 1'b0);
    queue_req(ACT_DEL,   8'h33, 16'h0000, 1'b0, 1'b0);
    queue_req(ACT_TOP,   8'h81, 16'h1234, 1'b1, 1'b1);
    queue_req(ACT_SERV + 1'b1, 8'h18, 16'h0000, 1'b0, 1'b0);
    queue_req(ACT_QUERY, 8'h00, 16'h0000, 1'b0, 1'b0);
    queue_req(ACT_SERV,  8'hC3, 16'h0000, 1'b0, 1'b0);

    // Random part: mostly adds, ticks and lookups on a small handle pool
    for (i = 0; i < POOL_SIZE; i++) pool[i] = handle_t'($urandom);
    calm = 1'b0;
    for (i = 0; i < RANDOM_REQS; i++) begin
      if (i % 30 == 0) calm = ($urandom_range(0, 2) == 0);
      sel     = $urandom_range(0, 99);
      r.hdl   = ($urandom_range(0, 4) == 0) ? handle_t'($urandom)
                                            : pool[$urandom_range(0, POOL_SIZE - 1)];
      r.dly   = time_t'($urandom);
      r.quick = 1'($urandom_range(0, 1));
      r.late  = 1'($urandom_range(0, 1));
      r.drain = (i == RANDOM_REQS / 2);
      if (sel < 36) begin
        r.act = ACT_ADD;
        case ($urandom_range(0, 9))
          0:       r.dly = '0;
          1:       r.dly = time_t'($urandom);
          default: r.dly = r.quick ? time_t'($urandom_range(1, 8))
                                   : time_t'($urandom_range(1, 30));
        endcase
      end else if (sel < 62) begin
        r.act = ACT_TICK;
      end else if (sel < 70) begin
        r.act = ACT_SERV;
      end else if (sel < 83) begin
        r.act = ACT_QUERY;
      end else if (sel < 96) begin
        r.act = ACT_DEL;
      end else begin
        r.act = action_t'($urandom_range(ACT_SERV + 1, ACT_TOP));
      end
      r.idle = (!calm && i < RANDOM_REQS - 40 && $urandom_range(0, 3) == 0)
               ? $urandom_range(1, 17) : 0;
      pending.push_back(r);
    end

    // Build up a tick backlog, then let service pull it off the long timer
    queue_req(ACT_ADD, pool[0], 16'hFFFF, 1'b0, 1'b0);
    pending[pending.size() - 1].drain = 1'b1;
    queue_req(ACT_ADD, pool[1], 16'hFFFF, 1'b1, 1'b0);
    for (i = 0; i < BACKLOG_TICKS; i++)
      queue_req(ACT_TICK, handle_t'($urandom), time_t'($urandom), 1'b0, 1'b0);
    queue_req(ACT_QUERY, pool[0], 16'h0000, 1'b0, 1'b0);
    queue_req(ACT_SERV,  pool[2], 16'h0000, 1'b0, 1'b0);
    queue_req(ACT_QUERY, pool[0], 16'h0000, 1'b0, 1'b0);
    queue_req(ACT_TICK,  pool[3], 16'h0000, 1'b0, 1'b0);

    while (pending.size() != 0 || start || replies_seen != replies_due_total)
      @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (due_replies.size() != 0) begin
      $display("%0d expected results never arrived", due_replies.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
design/tct_pkg.sv
design/tct_cell.sv
design/tct_row.sv
design/two_class_countdown_timer_table.sv
dv/tb_two_class_countdown_timer_table.sv
